/* hdl/crc8f_pkg.sv */
// ----------------------------------------------------------------------------
// crc8f_pkg
// Shared types, constants and the CRC-8 byte update for the packet framer.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8f_pkg;

	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hD5;
	localparam logic [BYTE_W-1:0] CRC_POLY_REFL = 8'h8C;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;
	localparam int QUEUE_DEPTH_DEF = 4;

	// one accepted payload beat, classified by the front end
	typedef struct packed {
		logic first;
		logic last;
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] length;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] crc;
	} frm_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_HEAD,
		BK_LEN,
		BK_DATA,
		BK_CRC
	} bk_state_t;

	// reflected crc-8, one byte
	function automatic logic [BYTE_W-1:0] crc8_update(
		input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data
	);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/crc8f_front.sv */
// ----------------------------------------------------------------------------
// crc8f_front
// Accepts payload beats, marks packet start and end, runs the CRC register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8f_front
	import crc8f_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] payload_byte,
	input  wire logic [BYTE_W-1:0] payload_length,
	input  wire logic              last_in_packet,
	input  wire logic [BYTE_W-1:0] start_byte,
	input  wire q_stat_t           q_stat,
	output logic                   push,
	output frm_entry_t             entry
);

	logic              inside_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_next;

	assign in_stall = q_stat.full;
	assign push     = in_valid && !q_stat.full;

	assign crc_base = inside_q ? crc_q : CRC_INIT;
	assign crc_next = crc8_update(crc_base, payload_byte);

	always_comb begin
		entry.first      = !inside_q;
		entry.last       = last_in_packet;
		entry.start_byte = start_byte;
		entry.length     = payload_length;
		entry.data       = payload_byte;
		entry.crc        = crc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			crc_q    <= CRC_INIT;
		end else if (push) begin
			inside_q <= !last_in_packet;
			crc_q    <= last_in_packet ? CRC_INIT : crc_next;
		end
	end

endmodule

`default_nettype wire

/* hdl/crc8f_queue.sv */
// ----------------------------------------------------------------------------
// crc8f_queue
// Short first-in first-out queue of classified beats between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8f_queue
	import crc8f_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire frm_entry_t                 wr_entry,
	input  wire logic                       pop,
	output frm_entry_t                      head,
	output q_stat_t                         q_stat,
	output logic [$clog2(DEPTH+1)-1:0]      count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	frm_entry_t        entries_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = entries_q[rd_ptr_q];
	assign count        = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/crc8f_back.sv */
// ----------------------------------------------------------------------------
// crc8f_back
// Expands queued beats into start, length, payload and crc output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8f_back
	import crc8f_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire frm_entry_t        head,
	input  wire q_stat_t           q_stat,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   frame_end
);

	bk_state_t         state_q;
	bk_state_t         state_nxt;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              frame_end_q;
	logic              load;
	logic              go;
	logic [BYTE_W-1:0] emit_byte;
	logic              emit_end;
	logic              emit_done;

	assign load = !out_valid_q || !out_stall;
	assign go   = load && !q_stat.empty;
	assign pop  = go && emit_done;

	// next state
	always_comb begin
		state_nxt = state_q;
		if (go) begin
			unique case (state_q)
				BK_HEAD: begin
					if (head.first) begin
						state_nxt = BK_LEN;
					end else if (head.last) begin
						state_nxt = BK_CRC;
					end else begin
						state_nxt = BK_HEAD;
					end
				end
				BK_LEN:  state_nxt = BK_DATA;
				BK_DATA: state_nxt = head.last ? BK_CRC : BK_HEAD;
				BK_CRC:  state_nxt = BK_HEAD;
				default: state_nxt = BK_HEAD;
			endcase
		end
	end

	// beat contents
	always_comb begin
		emit_byte = head.data;
		emit_end  = 1'b0;
		emit_done = 1'b0;
		unique case (state_q)
			BK_HEAD: begin
				emit_byte = head.first ? head.start_byte : head.data;
				emit_done = !head.first && !head.last;
			end
			BK_LEN: begin
				emit_byte = head.length;
			end
			BK_DATA: begin
				emit_byte = head.data;
				emit_done = !head.last;
			end
			BK_CRC: begin
				emit_byte = head.crc;
				emit_end  = 1'b1;
				emit_done = 1'b1;
			end
			default: begin
				emit_byte = head.data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_HEAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= !q_stat.empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_byte_q  <= emit_byte;
			frame_end_q <= emit_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign frame_end = frame_end_q;

endmodule

`default_nettype wire

/* hdl/crc8_packet_framer_top.sv */
// ----------------------------------------------------------------------------
// crc8_packet_framer_top
// Frames payload bytes with start byte, length and a trailing reflected CRC-8.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one payload beat carries payload_byte,
// payload_length and last_in_packet. payload_length is taken on the first beat
// of a packet only; last_in_packet closes the packet.
// Output channel (out_valid / out_stall): one framed byte per beat. A packet
// gives start byte, length, each payload byte, then the crc byte with
// frame_end high.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the start byte, used
// from the next frame on; cfg_ready is always high.
// A payload beat accepted at the input is written into the queue, then loaded
// into the back end's output register, from which the receiver takes it.
// Input beats are taken one per cycle while in_stall is low; the output side
// moves one beat per cycle while out_stall is low. The first beat of
// a packet and the last one expand in the back end, and the queue of
// QUEUE_DEPTH beats between front and back absorbs the extra header bytes.
// Reset clears the crc, the packet state and the queue; the start byte goes
// to 0xD5. While out_stall is high the output beat holds and the queue fills,
// after which in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_packet_framer_top
	import crc8f_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [BYTE_W-1:0] cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [BYTE_W-1:0] payload_byte,
	input  wire logic [BYTE_W-1:0] payload_length,
	input  wire logic              last_in_packet,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   frame_end
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [BYTE_W-1:0] start_byte_q;
	logic              q_push;
	logic              q_pop;
	frm_entry_t        q_wr_entry;
	frm_entry_t        q_head;
	q_stat_t           q_stat;
	logic [CW-1:0]     q_count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_byte_q <= cfg_data;
		end
	end

	crc8f_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.payload_byte   (payload_byte),
		.payload_length (payload_length),
		.last_in_packet (last_in_packet),
		.start_byte     (start_byte_q),
		.q_stat         (q_stat),
		.push           (q_push),
		.entry          (q_wr_entry)
	);

	crc8f_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr_entry),
		.pop      (q_pop),
		.head     (q_head),
		.q_stat   (q_stat),
		.count    (q_count)
	);

	crc8f_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_stat    (q_stat),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.frame_end (frame_end)
	);

	a_q_full_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_q_count_track : assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> q_count == $past(q_count) + CW'($past(q_push))
			- CW'($past(q_pop)))
		else $error("queue count out of step with push and pop");

	a_q_no_overflow : assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");

endmodule

`default_nettype wire
